// ===== rtl/tlhc_pkg.sv =====
// Shared types, constants and the CORDIC angle table of the leg height commander.
package tlhc_pkg;

  // Default number of CORDIC iterations
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Angle table index width (table holds 23 entries)
  localparam int unsigned ANG_IDX_W = 5;

  // CORDIC datapath widths: x/y in Q1.15 with headroom, z in degrees Q16
  localparam int unsigned XY_W = 18;
  localparam int unsigned Z_W  = 25;

  // Divider widths: rounded numerator and sin(el) divisor
  localparam int unsigned NUM_W = 36;
  localparam int unsigned DEN_W = 18;

  // Field and register widths
  localparam int unsigned H_W   = 14;
  localparam int unsigned MS_W  = 18;
  localparam int unsigned MM_W  = 10;
  localparam int unsigned CFG_W = 18;

  // Fixed-point constants
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(19898);
  localparam logic [16:0]            SQRT3_Q15   = 17'd56754;
  localparam logic [H_W-1:0]         MAX_HEIGHT  = 14'd16383;
  localparam logic [H_W-1:0]         FLAT_LO     = 14'd80;
  localparam logic [H_W-1:0]         FLAT_HI     = 14'd12640;
  localparam logic [H_W-1:0]         LEG_RESET   = 14'd9600;

  // Angle limits in sixteenths of a degree
  localparam logic signed [12:0] AZ_LO = -13'sd800;
  localparam logic signed [12:0] AZ_HI = 13'sd800;
  localparam logic signed [11:0] EL_LO = 12'sd720;
  localparam logic signed [11:0] EL_HI = 12'sd1439;

  // Operation codes
  typedef enum logic [1:0] {
    OP_DIR    = 2'd0,
    OP_FLAT   = 2'd1,
    OP_PRESET = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ARM    = 2'd0,
    CFG_CENTER = 2'd1,
    CFG_MIN    = 2'd2,
    CFG_MS     = 2'd3
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORD_AZ,
    ST_CORD_EL,
    ST_MUL_CT,
    ST_MUL_SA,
    ST_BRACKET,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ROUND,
    ST_DIV_RUN,
    ST_TARGET,
    ST_DRIVE_ONE,
    ST_DRIVE_TWO,
    ST_EMIT
  } state_e;

  // CORDIC rotation vector
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [ANG_IDX_W-1:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      5'd0:    a = Z_W'(2949120);
      5'd1:    a = Z_W'(1740967);
      5'd2:    a = Z_W'(919879);
      5'd3:    a = Z_W'(466945);
      5'd4:    a = Z_W'(234379);
      5'd5:    a = Z_W'(117304);
      5'd6:    a = Z_W'(58666);
      5'd7:    a = Z_W'(29335);
      5'd8:    a = Z_W'(14668);
      5'd9:    a = Z_W'(7334);
      5'd10:   a = Z_W'(3667);
      5'd11:   a = Z_W'(1833);
      5'd12:   a = Z_W'(917);
      5'd13:   a = Z_W'(458);
      5'd14:   a = Z_W'(229);
      5'd15:   a = Z_W'(115);
      5'd16:   a = Z_W'(57);
      5'd17:   a = Z_W'(29);
      5'd18:   a = Z_W'(14);
      5'd19:   a = Z_W'(7);
      5'd20:   a = Z_W'(4);
      5'd21:   a = Z_W'(2);
      5'd22:   a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/tlhc_cordic.sv =====
// One rotation-mode CORDIC iteration, shared by the azimuth and elevation passes.
module tlhc_cordic (
  input  tlhc_pkg::cordic_vec_t               vec_i,
  input  logic [tlhc_pkg::ANG_IDX_W-1:0]      idx_i,
  output tlhc_pkg::cordic_vec_t               vec_o
);
  import tlhc_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  ang;

  // arithmetic shifts floor towards minus infinity
  assign dx  = vec_i.y >>> idx_i;
  assign dy  = vec_i.x >>> idx_i;
  assign ang = atan_q16(idx_i);

  // rotate towards zero residual angle
  always_comb begin
    if (!vec_i.z[Z_W-1]) begin
      vec_o.x = vec_i.x - dx;
      vec_o.y = vec_i.y + dy;
      vec_o.z = vec_i.z - ang;
    end else begin
      vec_o.x = vec_i.x + dx;
      vec_o.y = vec_i.y - dy;
      vec_o.z = vec_i.z + ang;
    end
  end

endmodule

// ===== rtl/tlhc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tlhc_div #(
  parameter int unsigned NumW = tlhc_pkg::NUM_W,
  parameter int unsigned DenW = tlhc_pkg::DEN_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   rem_nx;
  logic            ge;

  // trial subtract of the next dividend bit
  assign trial  = {rem_q, quot_q[NumW-1]};
  assign ge     = trial >= {1'b0, den_q};
  assign rem_nx = ge ? trial - {1'b0, den_q} : trial;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[NumW-2:0], ge};
      rem_q  <= rem_nx[DenW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/tracker_leg_height_commander.sv =====
// Top level of the leg height commander: sequencer, datapath and leg height store.
//
// Input channel (in_valid_i/in_ready_o) takes one pointing command per
// transaction; the output channel (out_valid_o/out_ready_i) returns one
// result per command. The configuration port writes a register whenever
// cfg_we_i is high; write it only while the block is idle.
// Steps from acceptance to the result register:
//   direction command: two CORDIC passes through the shared iteration
//   unit, then per leg two partial products, a rounding step and a
//   36-bit restoring division, then two drive time products; flat command
//   in range: the two drive time products; other flat, preset or ignored: none.
// One command is worked on at a time; in_ready_o is high only between
// commands. The result sits in an output register, so a new command is
// taken while the previous result waits; a stalled receiver holds the next
// result back in the final state until the register frees.
// Reset loads the register defaults and sets both stored legs to 600 mm.
module tracker_leg_height_commander #(
  parameter int unsigned CORDIC_STEPS = tlhc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [tlhc_pkg::CFG_W-1:0]   cfg_data_i,
  // command channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic signed [12:0]           azimuth_q4_i,
  input  logic signed [11:0]           elevation_q4_i,
  input  logic [tlhc_pkg::H_W-1:0]     height_a_q4_i,
  input  logic [tlhc_pkg::H_W-1:0]     height_b_q4_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         moved_o,
  output logic [tlhc_pkg::H_W-1:0]     target_one_q4_o,
  output logic [tlhc_pkg::H_W-1:0]     target_two_q4_o,
  output logic                         up_one_o,
  output logic                         up_two_o,
  output logic [tlhc_pkg::MS_W-1:0]    drive_ms_one_o,
  output logic [tlhc_pkg::MS_W-1:0]    drive_ms_two_o
);
  import tlhc_pkg::*;

  localparam int unsigned StepW = $clog2(CORDIC_STEPS);
  localparam int unsigned BW    = 37;

  state_e state_q, state_d;

  // configuration and stored heights
  logic [MM_W-1:0] arm_q, center_q;
  logic [H_W-1:0]  min_q;
  logic [MS_W-1:0] ms_q;
  logic [H_W-1:0]  leg1_q, leg2_q;

  // sequencing
  logic [StepW-1:0] step_q;
  logic             leg_q;
  logic             out_valid_q;

  // datapath registers
  cordic_vec_t            vec_q, vec_nx;
  logic signed [11:0]     el_q;
  logic [XY_W-1:0]        ca_q, se_q;
  logic signed [XY_W-1:0] sa_q, ce_q;
  logic signed [28:0]     ct_q;
  logic signed [35:0]     p_q;
  logic signed [BW-1:0]   b1_q, b2_q;
  logic signed [63:0]     acc_q;
  logic                   neg_q;
  logic                   move_q;
  logic [H_W-1:0]         t1_q, t2_q;
  logic                   up1_q, up2_q;
  logic [MS_W-1:0]        drv1_q, drv2_q;

  // result register
  logic            moved_q, rup1_q, rup2_q;
  logic [H_W-1:0]  rt1_q, rt2_q;
  logic [MS_W-1:0] rdrv1_q, rdrv2_q;

  // combinational
  logic                   in_fire, emit_fire, last_step;
  logic signed [12:0]     az_c;
  logic signed [11:0]     el_c;
  logic                   flat_ok;
  logic [H_W-1:0]         flat_t;
  logic [XY_W-1:0]        ca_abs;
  logic signed [BW-1:0]   bsel;
  logic signed [46:0]     prod_lo;
  logic signed [48:0]     prod_hi;
  logic [19:0]            ca3;
  logic signed [BW-1:0]   term3;
  logic [63:0]            mag, rsum;
  logic                   div_start, div_done;
  logic [NUM_W-1:0]       quot;
  logic signed [37:0]     t_s;
  logic [H_W-1:0]         t_clamp;
  logic [H_W-1:0]         dt, ds;
  logic [H_W-1:0]         diff;
  logic                   up_now;
  logic [31:0]            drv_prod;
  logic [MS_W-1:0]        drv_sat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign last_step  = (step_q == StepW'(CORDIC_STEPS - 1));

  // shared CORDIC iteration
  tlhc_cordic u_cordic (
    .vec_i (vec_q),
    .idx_i (ANG_IDX_W'(step_q)),
    .vec_o (vec_nx)
  );

  // shared divider for both legs
  tlhc_div #(
    .NumW (NUM_W),
    .DenW (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rsum[62:27]),
    .divisor_i  (se_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // input clamps and flat range check
  always_comb begin
    if (azimuth_q4_i < AZ_LO)      az_c = AZ_LO;
    else if (azimuth_q4_i > AZ_HI) az_c = AZ_HI;
    else                           az_c = azimuth_q4_i;
    if (elevation_q4_i > EL_HI)      el_c = EL_HI;
    else if (elevation_q4_i < EL_LO) el_c = EL_LO;
    else                             el_c = elevation_q4_i;
    flat_ok = (height_a_q4_i >= FLAT_LO) && (height_a_q4_i <= FLAT_HI);
    flat_t  = (height_a_q4_i < min_q) ? min_q : height_a_q4_i;
  end

  // bracket, product and rounding arithmetic
  always_comb begin
    ca_abs  = vec_nx.x[XY_W-1] ? XY_W'(-vec_nx.x) : vec_nx.x;
    ca3     = {2'b0, ca_q} + {1'b0, ca_q, 1'b0};
    term3   = $signed({2'b0, ca3, 15'b0});
    bsel    = leg_q ? b2_q : b1_q;
    prod_lo = ct_q * $signed({1'b0, bsel[16:0]});
    prod_hi = ct_q * $signed(bsel[BW-1:17]);
    mag     = acc_q[63] ? 64'(-acc_q) : acc_q;
    rsum    = mag + {20'b0, se_q, 26'b0};
  end

  // target from quotient, clamped
  always_comb begin
    if (neg_q) t_s = $signed({24'b0, center_q, 4'b0}) + $signed({2'b0, quot});
    else       t_s = $signed({24'b0, center_q, 4'b0}) - $signed({2'b0, quot});
    if (t_s < $signed({24'b0, min_q}))  t_clamp = min_q;
    else if (t_s > 38'sd16383)          t_clamp = MAX_HEIGHT;
    else                                t_clamp = t_s[H_W-1:0];
  end

  // drive time against the stored height
  always_comb begin
    dt       = (state_q == ST_DRIVE_TWO) ? t2_q : t1_q;
    ds       = (state_q == ST_DRIVE_TWO) ? leg2_q : leg1_q;
    up_now   = dt >= ds;
    diff     = up_now ? dt - ds : ds - dt;
    drv_prod = diff * ms_q;
    drv_sat  = (|drv_prod[31:30]) ? '1 : drv_prod[29:12];
  end

  // next state and divider start
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_e'(operation_i))
            OP_DIR:    state_d = ST_CORD_AZ;
            OP_FLAT:   state_d = flat_ok ? ST_DRIVE_ONE : ST_EMIT;
            OP_PRESET: state_d = ST_EMIT;
            OP_NONE:   state_d = ST_EMIT;
          endcase
        end
      end
      ST_CORD_AZ:   if (last_step) state_d = ST_CORD_EL;
      ST_CORD_EL:   if (last_step) state_d = ST_MUL_CT;
      ST_MUL_CT:    state_d = ST_MUL_SA;
      ST_MUL_SA:    state_d = ST_BRACKET;
      ST_BRACKET:   state_d = ST_MUL_LO;
      ST_MUL_LO:    state_d = ST_MUL_HI;
      ST_MUL_HI:    state_d = ST_ROUND;
      ST_ROUND: begin
        div_start = 1'b1;
        state_d   = ST_DIV_RUN;
      end
      ST_DIV_RUN:   if (div_done) state_d = ST_TARGET;
      ST_TARGET:    state_d = leg_q ? ST_DRIVE_ONE : ST_MUL_LO;
      ST_DRIVE_ONE: state_d = ST_DRIVE_TWO;
      ST_DRIVE_TWO: state_d = ST_EMIT;
      ST_EMIT:      if (emit_fire) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control state, configuration and stored heights
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      leg_q       <= 1'b0;
      arm_q       <= 10'd300;
      center_q    <= 10'd600;
      min_q       <= 14'd800;
      ms_q        <= 18'd48302;
      leg1_q      <= LEG_RESET;
      leg2_q      <= LEG_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ARM:    arm_q    <= cfg_data_i[MM_W-1:0];
          CFG_CENTER: center_q <= cfg_data_i[MM_W-1:0];
          CFG_MIN:    min_q    <= cfg_data_i[H_W-1:0];
          CFG_MS:     ms_q     <= cfg_data_i[MS_W-1:0];
        endcase
      end
      if (in_fire) step_q <= '0;
      else if (state_q == ST_CORD_AZ || state_q == ST_CORD_EL)
        step_q <= last_step ? '0 : step_q + 1'b1;
      if (state_q == ST_BRACKET) leg_q <= 1'b0;
      else if (state_q == ST_TARGET) leg_q <= 1'b1;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        leg1_q      <= t1_q;
        leg2_q      <= t2_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          vec_q  <= '{x: CORDIC_GAIN, y: '0, z: $signed({az_c, 12'b0})};
          el_q   <= el_c;
          up1_q  <= 1'b0;
          up2_q  <= 1'b0;
          drv1_q <= '0;
          drv2_q <= '0;
          unique case (op_e'(operation_i))
            OP_DIR: begin
              move_q <= 1'b1;
              t1_q   <= leg1_q;
              t2_q   <= leg2_q;
            end
            OP_FLAT: begin
              move_q <= flat_ok;
              t1_q   <= flat_ok ? flat_t : leg1_q;
              t2_q   <= flat_ok ? flat_t : leg2_q;
            end
            OP_PRESET: begin
              move_q <= 1'b0;
              t1_q   <= height_a_q4_i;
              t2_q   <= height_b_q4_i;
            end
            OP_NONE: begin
              move_q <= 1'b0;
              t1_q   <= leg1_q;
              t2_q   <= leg2_q;
            end
          endcase
        end
      end
      ST_CORD_AZ: begin
        if (last_step) begin
          ca_q  <= ca_abs;
          sa_q  <= vec_nx.y;
          vec_q <= '{x: CORDIC_GAIN, y: '0, z: $signed({1'b0, el_q, 12'b0})};
        end else begin
          vec_q <= vec_nx;
        end
      end
      ST_CORD_EL: begin
        vec_q <= vec_nx;
        if (last_step) begin
          ce_q <= vec_nx.x;
          se_q <= (vec_nx.y < $signed(XY_W'(1))) ? XY_W'(1) : vec_nx.y;
        end
      end
      ST_MUL_CT: ct_q <= $signed({1'b0, arm_q}) * ce_q;
      ST_MUL_SA: p_q  <= $signed({1'b0, SQRT3_Q15}) * sa_q;
      ST_BRACKET: begin
        b1_q <= term3 + BW'(p_q);
        b2_q <= term3 - BW'(p_q);
      end
      ST_MUL_LO: acc_q <= 64'(prod_lo);
      ST_MUL_HI: acc_q <= acc_q + (64'(prod_hi) <<< 17);
      ST_ROUND:  neg_q <= acc_q[63];
      ST_TARGET: begin
        if (leg_q) t2_q <= t_clamp;
        else       t1_q <= t_clamp;
      end
      ST_DRIVE_ONE: begin
        up1_q  <= up_now;
        drv1_q <= drv_sat;
      end
      ST_DRIVE_TWO: begin
        up2_q  <= up_now;
        drv2_q <= drv_sat;
      end
      default: ;
    endcase
    // result register
    if (emit_fire) begin
      moved_q <= move_q;
      rt1_q   <= t1_q;
      rt2_q   <= t2_q;
      rup1_q  <= up1_q;
      rup2_q  <= up2_q;
      rdrv1_q <= drv1_q;
      rdrv2_q <= drv2_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign moved_o         = moved_q;
  assign target_one_q4_o = rt1_q;
  assign target_two_q4_o = rt2_q;
  assign up_one_o        = rup1_q;
  assign up_two_o        = rup2_q;
  assign drive_ms_one_o  = rdrv1_q;
  assign drive_ms_two_o  = rdrv2_q;

  // an accepted command always moves the sequencer out of idle in the cycle after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("command accepted but sequencer stayed idle");

  // a result without a move (ignored, preset or out-of-range flat) carries no drive order
  a_no_move_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !moved_o |-> (!up_one_o && !up_two_o &&
                                 drive_ms_one_o == '0 && drive_ms_two_o == '0))
    else $error("drive order on a result without a move");

  // divider is only started from the rounding step
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == ST_DIV_RUN)
    else $error("divider started outside the leg sequence");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the leg height commander: directed, configuration and random tests.
module tb;
  import tlhc_pkg::*;

  localparam int unsigned STEPS       = 16;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned SETTLE      = 200;

  // Expected result of one command
  typedef struct {
    logic          moved;
    logic [H_W-1:0] t1;
    logic [H_W-1:0] t2;
    logic          up1;
    logic          up2;
    logic [MS_W-1:0] ms1;
    logic [MS_W-1:0] ms2;
  } leg_order_t;

  localparam longint ANGLE_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic signed [12:0] az = '0;
  logic signed [11:0] el = '0;
  logic [H_W-1:0] ha = '0;
  logic [H_W-1:0] hb = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic moved;
  logic [H_W-1:0] t_one, t_two;
  logic up_one, up_two;
  logic [MS_W-1:0] ms_one, ms_two;

  // predictor copy of registers and leg store
  longint radius_mm, center_mm, min_q4, ms_q8;
  longint leg_one, leg_two;

  leg_order_t pending_orders[$];
  int unsigned errors = 0;
  int unsigned cmds_sent = 0;
  int unsigned results_seen = 0;
  int unsigned moves_seen = 0;
  int unsigned cycles = 0;
  bit send_burst = 1'b0;

  tracker_leg_height_commander u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op), .azimuth_q4_i(az), .elevation_q4_i(el),
    .height_a_q4_i(ha), .height_b_q4_i(hb),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .moved_o(moved), .target_one_q4_o(t_one), .target_two_q4_o(t_two),
    .up_one_o(up_one), .up_two_o(up_two),
    .drive_ms_one_o(ms_one), .drive_ms_two_o(ms_two)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // rotation-mode CORDIC, Q1.15 outputs
  function automatic void rotate_deg(input longint z_in, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 19898;
    y = 0;
    z = z_in;
    for (int i = 0; i < STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x = x - dy; y = y + dx; z = z - ANGLE_Q16[i];
      end else begin
        x = x + dy; y = y - dx; z = z + ANGLE_Q16[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (mag + d / 2) / d;
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_leg(longint h);
    if (h < min_q4) h = min_q4;
    if (h > 16383) h = 16383;
    return h;
  endfunction

  function automatic longint drive_ms(longint a, longint b);
    longint d, t;
    d = (a > b) ? a - b : b - a;
    t = (d * ms_q8) >>> 12;
    return (t > 262143) ? 262143 : t;
  endfunction

  // works out the result of one command and updates the leg store
  function automatic leg_order_t predict_legs(op_e code, logic signed [12:0] az_in,
                                              logic signed [11:0] el_in,
                                              logic [H_W-1:0] a_in, logic [H_W-1:0] b_in);
    leg_order_t r;
    longint a, e, ca, sa, ce, se, br1, br2, ct, base, n1, n2;
    n1 = leg_one;
    n2 = leg_two;
    r.moved = 1'b0;
    case (code)
      OP_DIR: begin
        a = longint'(az_in);
        e = longint'(el_in);
        if (a < -800) a = -800;
        if (a > 800) a = 800;
        if (e > 1439) e = 1439;
        if (e < 720) e = 720;
        rotate_deg(a * 4096, ca, sa);
        rotate_deg(e * 4096, ce, se);
        if (ca < 0) ca = -ca;
        if (se < 1) se = 1;
        br1 = 3 * ca * 32768 + 56754 * sa;
        br2 = 3 * ca * 32768 - 56754 * sa;
        ct = radius_mm * ce;
        base = center_mm * 16;
        n1 = clamp_leg(base - round_div(ct * br1, se * (longint'(1) << 27)));
        n2 = clamp_leg(base - round_div(ct * br2, se * (longint'(1) << 27)));
        r.moved = 1'b1;
      end
      OP_FLAT: begin
        if (a_in >= FLAT_LO && a_in <= FLAT_HI) begin
          n1 = clamp_leg(a_in);
          n2 = n1;
          r.moved = 1'b1;
        end
      end
      OP_PRESET: begin
        leg_one = a_in;
        leg_two = b_in;
        n1 = a_in;
        n2 = b_in;
      end
      default: ;
    endcase
    r.t1 = n1[H_W-1:0];
    r.t2 = n2[H_W-1:0];
    if (r.moved) begin
      r.up1 = (n1 >= leg_one);
      r.up2 = (n2 >= leg_two);
      r.ms1 = drive_ms(n1, leg_one);
      r.ms2 = drive_ms(n2, leg_two);
      leg_one = n1;
      leg_two = n2;
    end else begin
      r.up1 = 1'b0; r.up2 = 1'b0; r.ms1 = '0; r.ms2 = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  // sends one command; called at a rising edge, returns at its acceptance edge
  task automatic send_cmd(op_e code, logic signed [12:0] a, logic signed [11:0] e,
                          logic [H_W-1:0] h1, logic [H_W-1:0] h2);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= code;
    az <= a;
    el <= e;
    ha <= h1;
    hb <= h2;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_orders.push_back(predict_legs(code, a, e, h1, h2));
    cmds_sent++;
  endtask

  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    wait (pending_orders.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, longint value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ARM:    radius_mm = value & 'h3FF;
      CFG_CENTER: center_mm = value & 'h3FF;
      CFG_MIN:    min_q4 = value & 'h3FFF;
      default:    ms_q8 = value & 'h3FFFF;
    endcase
  endtask

  task automatic write_all(longint r, longint c, longint m, longint s);
    write_reg(CFG_ARM, r);
    write_reg(CFG_CENTER, c);
    write_reg(CFG_MIN, m);
    write_reg(CFG_MS, s);
  endtask

  // one random command: mostly in-range, some full-width noise
  task automatic send_random;
    op_e code;
    logic signed [12:0] a;
    logic signed [11:0] e;
    logic [H_W-1:0] h1, h2;
    case ($urandom_range(0, 19))
      0:             code = OP_NONE;
      1, 2, 3:       code = OP_PRESET;
      4, 5, 6, 7, 8: code = OP_FLAT;
      default:       code = OP_DIR;
    endcase
    if ($urandom_range(0, 4) == 0) begin
      a = 13'($urandom);
      e = 12'($urandom);
    end else begin
      a = 13'(int'($urandom_range(0, 1600)) - 800);
      e = 12'($urandom_range(720, 1439));
    end
    h1 = ($urandom_range(0, 4) == 0) ? 14'($urandom) : 14'($urandom_range(80, 12640));
    h2 = 14'($urandom);
    send_cmd(code, a, e, h1, h2);
  endtask

  // result side: random stalls, check at each transaction
  initial begin : result_monitor
    int stall;
    bit hold_ready;
    leg_order_t w;
    hold_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) hold_ready = ~hold_ready;
      stall = hold_ready ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      results_seen++;
      if (pending_orders.size() == 0) begin
        $display("unexpected result %0d", results_seen);
        errors++;
      end else begin
        w = pending_orders.pop_front();
        if (moved !== w.moved) report_mismatch("moved", moved, w.moved);
        if (t_one !== w.t1) report_mismatch("target_one", t_one, w.t1);
        if (t_two !== w.t2) report_mismatch("target_two", t_two, w.t2);
        if (up_one !== w.up1) report_mismatch("up_one", up_one, w.up1);
        if (up_two !== w.up2) report_mismatch("up_two", up_two, w.up2);
        if (ms_one !== w.ms1) report_mismatch("drive_ms_one", ms_one, w.ms1);
        if (ms_two !== w.ms2) report_mismatch("drive_ms_two", ms_two, w.ms2);
        if (w.moved) moves_seen++;
      end
      @(posedge clk);
    end
  end

  // defaults after reset
  task automatic test_reset_state;
    send_cmd(OP_PRESET, 13'sd0, 12'sd0, 14'd9600, 14'd9600);
    send_cmd(OP_DIR, 13'sd0, 12'sd720, 14'd0, 14'd0);
    send_cmd(OP_FLAT, 13'sd0, 12'sd0, 14'd9600, 14'd0);
    drain();
  endtask

  // field extremes, every operation and the clamping cases
  task automatic test_directed;
    send_cmd(OP_DIR, -13'sd4096, -12'sd2048, 14'h3FFF, 14'h3FFF);
    send_cmd(OP_DIR, 13'sd4095, 12'sd2047, 14'd0, 14'd0);
    send_cmd(OP_DIR, -13'sd801, 12'sd719, 14'd0, 14'd0);
    send_cmd(OP_DIR, 13'sd801, 12'sd1440, 14'd0, 14'd0);
    send_cmd(OP_DIR, -13'sd800, 12'sd720, 14'd0, 14'd0);
    send_cmd(OP_DIR, 13'sd800, 12'sd1439, 14'd0, 14'd0);
    send_cmd(OP_DIR, -13'sd2880, -12'sd1440, 14'd0, 14'd0);
    send_cmd(OP_DIR, 13'sd2880, 12'sd1440, 14'd0, 14'd0);
    send_cmd(OP_FLAT, 13'sd0, 12'sd0, 14'd79, 14'd0);
    send_cmd(OP_FLAT, 13'sd0, 12'sd0, 14'd80, 14'd0);
    send_cmd(OP_FLAT, 13'sd0, 12'sd0, 14'd12640, 14'd0);
    send_cmd(OP_FLAT, 13'sd0, 12'sd0, 14'd12641, 14'd0);
    send_cmd(OP_FLAT, 13'sd0, 12'sd0, 14'd500, 14'd0);
    send_cmd(OP_FLAT, 13'sd0, 12'sd0, 14'h3FFF, 14'd0);
    send_cmd(OP_PRESET, 13'sd0, 12'sd0, 14'd0, 14'h3FFF);
    send_cmd(OP_FLAT, 13'sd0, 12'sd0, 14'd8000, 14'd0);
    send_cmd(OP_PRESET, 13'sd0, 12'sd0, 14'h3FFF, 14'd0);
    send_cmd(OP_NONE, 13'sd100, 12'sd900, 14'd5000, 14'd5000);
    send_cmd(OP_DIR, 13'sd0, 12'sd1439, 14'd0, 14'd0);
    drain();
  endtask

  // register extremes, each followed by a few commands
  task automatic test_config_extremes;
    write_all(1, 0, 0, 1);
    repeat (10) send_random();
    drain();
    write_all(1023, 1023, 16383, 262143);
    repeat (10) send_random();
    drain();
    write_all(1023, 0, 0, 262143);
    repeat (10) send_random();
    drain();
    write_all(300, 600, 800, 48302);
  endtask

  // random commands across several register settings, with one full pause
  task automatic test_random_traffic;
    for (int p = 0; p < 8; p++) begin
      if (p > 0) write_all($urandom_range(1, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 3000), $urandom_range(1, 262143));
      for (int k = 0; k < 190; k++) begin
        send_random();
        if (p == 3 && k == 90) begin
          in_valid <= 1'b0;
          wait (pending_orders.size() == 0);
          @(posedge clk);
        end
      end
      drain();
    end
  endtask

  initial begin
    radius_mm = 300; center_mm = 600; min_q4 = 800; ms_q8 = 48302;
    leg_one = 9600; leg_two = 9600;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_config_extremes();
    test_random_traffic();
    wait (pending_orders.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d commands, checked %0d results, %0d of them moves",
             cmds_sent, results_seen, moves_seen);
    $display("covered direction, flat, preset and ignored commands over several register settings");
    if (errors == 0 && pending_orders.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlhc_pkg.sv
rtl/tlhc_cordic.sv
rtl/tlhc_div.sv
rtl/tracker_leg_height_commander.sv
dv/tb.sv
